>>> rtl/core/skct_pkg.sv
// ----------------------------------------------------------------------------
// skct_pkg
// Shared types and codes for the sorted key count table.
// ----------------------------------------------------------------------------
package skct_pkg;

  // Function codes on the request channel
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_NEW_ENTRY = 3'd0,
    ST_COUNT_INC = 3'd1,
    ST_LOOKUP_HIT = 3'd2,
    ST_LOOKUP_MISS = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  // Request payload
  typedef struct packed {
    logic        func;
    logic [63:0] key;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  position;
    logic [31:0] occurrences;
    logic [8:0]  entries_used;
  } rsp_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } fsm_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic cmp;  // latch compare flags against the broadcast key
    logic ins;  // open a slot at the insertion point, shift larger entries up
    logic inc;  // bump the count of the matching entry
  } cell_ctl_t;

endpackage

>>> rtl/core/skct_cell.sv
// ----------------------------------------------------------------------------
// skct_cell
// One table slot: holds a key and its count, compares against the broadcast
// key and takes its lower neighbor's entry when the table shifts up.
// ----------------------------------------------------------------------------
module skct_cell #(
  parameter int IDX        = 0,
  parameter int KEY_BITS   = 64,
  parameter int COUNT_BITS = 32,
  parameter int OCC_W      = 9
) (
  input  logic                    clk,
  input  skct_pkg::cell_ctl_t     ctl,
  input  logic [KEY_BITS-1:0]     key_in,
  input  logic [OCC_W-1:0]        occupancy,
  input  logic                    prev_below,
  input  logic [KEY_BITS-1:0]     prev_key,
  input  logic [COUNT_BITS-1:0]   prev_count,
  output logic                    below,
  output logic                    eq,
  output logic                    at_pos,
  output logic [KEY_BITS-1:0]     key,
  output logic [COUNT_BITS-1:0]   count
);
  import skct_pkg::*;

  localparam logic [OCC_W-1:0] MY_IDX = OCC_W'(IDX);

  logic occupied;
  logic in_range;
  logic beyond;

  // Slot occupancy from the fill count
  assign occupied = MY_IDX < occupancy;
  assign in_range = MY_IDX <= occupancy;

  // Insertion point sits right after the last smaller entry
  assign at_pos = prev_below & ~below & in_range;
  assign beyond = ~prev_below & in_range;

  // Compare flags
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      below <= occupied & (key < key_in);
      eq    <= occupied & (key == key_in);
    end
  end

  // Entry storage: insert, shift or count
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (at_pos) begin
        key   <= key_in;
        count <= COUNT_BITS'(1);
      end else if (beyond) begin
        key   <= prev_key;
        count <= prev_count;
      end
    end else if (ctl.inc && eq) begin
      if (count != {COUNT_BITS{1'b1}}) begin
        count <= count + COUNT_BITS'(1);
      end
    end
  end

endmodule

>>> rtl/core/sorted_key_count_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_count_table_unit
// Ascending key table with occurrence counts, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each request passes two steps: a compare step, where every cell compares its
// key with the request key, and an update step, where the position and count
// are resolved and the cells insert, shift or count together. A new request
// is taken in the update step of the previous one and compared once that
// update is done; the update step waits only while a finished result is still
// held on a stalled result channel. Inserts into a full table are reported and
// dropped, counts saturate, and the table starts empty after reset.
module sorted_key_count_table_unit #(
  parameter int DEPTH      = 256,
  parameter int KEY_BITS   = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  skct_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output skct_pkg::rsp_t out_data
);
  import skct_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

  fsm_t state, state_next;
  logic [OCC_W-1:0]      occupancy;
  logic                  func;
  logic [KEY_BITS-1:0]   key;
  cell_ctl_t             ctl;
  logic                  accept;
  logic                  finish;

  logic                  below_v  [DEPTH];
  logic                  eq_v     [DEPTH];
  logic                  at_pos_v [DEPTH];
  logic [KEY_BITS-1:0]   key_v    [DEPTH];
  logic [COUNT_BITS-1:0] count_v  [DEPTH];

  logic                  hit;
  logic                  any_pos;
  logic [OCC_W-1:0]      pos;
  logic [COUNT_BITS-1:0] hit_count;
  logic [COUNT_BITS-1:0] inc_count;
  rsp_t                  rsp;
  logic                  do_ins;
  logic                  do_inc;

  // Row of slot cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  pb;
    logic [KEY_BITS-1:0]   pk;
    logic [COUNT_BITS-1:0] pc;
    if (i == 0) begin : g_first
      assign pb = 1'b1;
      assign pk = '0;
      assign pc = '0;
    end else begin : g_rest
      assign pb = below_v[i-1];
      assign pk = key_v[i-1];
      assign pc = count_v[i-1];
    end
    skct_cell #(
      .IDX(i), .KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS), .OCC_W(OCC_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key_in    (key),
      .occupancy (occupancy),
      .prev_below(pb),
      .prev_key  (pk),
      .prev_count(pc),
      .below     (below_v[i]),
      .eq        (eq_v[i]),
      .at_pos    (at_pos_v[i]),
      .key       (key_v[i]),
      .count     (count_v[i])
    );
  end

  // Resolve position and matching count from the cell flags
  always_comb begin
    hit       = 1'b0;
    any_pos   = 1'b0;
    pos       = '0;
    hit_count = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit       = hit | eq_v[i];
      any_pos   = any_pos | at_pos_v[i];
      pos       = pos | (at_pos_v[i] ? OCC_W'(i) : '0);
      hit_count = hit_count | (eq_v[i] ? count_v[i] : '0);
    end
    if (!any_pos) begin
      pos = FULL_OCC;
    end
  end

  assign inc_count = (hit_count == {COUNT_BITS{1'b1}}) ? hit_count
                                                      : hit_count + COUNT_BITS'(1);

  // Result and update decisions
  always_comb begin
    do_ins = 1'b0;
    do_inc = 1'b0;
    rsp.position     = 9'(pos);
    rsp.occurrences  = '0;
    rsp.entries_used = 9'(occupancy);
    if (func == FUNC_LOOKUP) begin
      rsp.status = hit ? ST_LOOKUP_HIT : ST_LOOKUP_MISS;
      if (hit) begin
        rsp.occurrences = 32'(hit_count);
      end
    end else if (hit) begin
      do_inc          = 1'b1;
      rsp.status      = ST_COUNT_INC;
      rsp.occurrences = 32'(inc_count);
    end else if (occupancy >= FULL_OCC) begin
      rsp.status = ST_TABLE_FULL;
    end else begin
      do_ins           = 1'b1;
      rsp.status       = ST_NEW_ENTRY;
      rsp.occurrences  = 32'd1;
      rsp.entries_used = 9'(occupancy + OCC_W'(1));
    end
  end

  // Sequencer: next state and cell commands
  always_comb begin
    finish     = (state == S_UPD) && !(out_valid && out_stall);
    in_stall   = !((state == S_IDLE) || finish);
    accept     = in_valid && !in_stall;
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CMP;
      end
      S_CMP: begin
        ctl.cmp    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        if (finish) begin
          ctl.ins    = do_ins;
          ctl.inc    = do_inc;
          state_next = accept ? S_CMP : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
    end else begin
      state <= state_next;
      if (ctl.ins) begin
        occupancy <= occupancy + OCC_W'(1);
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func <= in_data.func;
      key  <= in_data.key[KEY_BITS-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= rsp;
    end
  end

endmodule
